/* hw/rtl/ohash_pkg.sv */
// ----------------------------------------------------------------------------
// ohash_pkg
// Shared types and constants of the open-addressed hash table.
// ----------------------------------------------------------------------------
package ohash_pkg;

  localparam int DEF_SLOTS     = 1024;
  localparam int DEF_KEY_BITS  = 32;
  localparam int DEF_DATA_BITS = 32;
  localparam int HASH_W        = 32;
  localparam int CFG_W         = 11;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOSLOT   = 3'd4;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_VACATED = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV1,
    S_DIV2,
    S_RD,
    S_CHK,
    S_FIN
  } state_t;

endpackage

/* hw/rtl/ohash_mod.sv */
// ----------------------------------------------------------------------------
// ohash_mod
// Bit-serial remainder unit: one dividend bit per cycle against the slot count.
// ----------------------------------------------------------------------------
module ohash_mod import ohash_pkg::*; #(
  parameter int PW = CFG_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [PW-1:0]     divisor,
  output logic              done,
  output logic [PW-1:0]     rem
);

  localparam int CNTW = $clog2(HASH_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [HASH_W-1:0] num_r, num_nxt;
  logic [PW-1:0]     rem_r, rem_nxt;
  logic [PW:0]       trial;

  always_comb begin
    trial    = {rem_r, num_r[HASH_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = PW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = PW'(trial);
      end
      num_nxt = {num_r[HASH_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(HASH_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hw/rtl/ohash_ram.sv */
// ----------------------------------------------------------------------------
// ohash_ram
// Slot memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ohash_ram import ohash_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS,
  parameter int W     = 2 + DEF_KEY_BITS + DEF_DATA_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [W-1:0]             rd_data
);

  logic [W-1:0] mem [SLOTS];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/open_addressed_hash_table_top.sv */
// ----------------------------------------------------------------------------
// open_addressed_hash_table_top
// Open-addressed hash table with double hashing and vacated-slot markers.
//
// A request transfer on the in_ channel carries an operation (insert, remove
// or lookup), a key, a payload and two caller-computed hashes. Each request
// gives exactly one result transfer on the out_ channel with a status, the
// matched payload and the slot index. The cfg_ channel sets the number of
// slots in use; a write is honored only while the table holds no entries
// and it empties the table.
// A request reduces both hashes by the slot count in a shared bit-serial
// remainder unit, one after the other, then probes the slot memory through
// its registered read port; each probe reads a slot, then checks it.
// A full-table insert or an unused operation skips the reduction and probing
// and goes straight to its result. One request is in flight at a time, and
// in_tready is high only while the sequencer is idle. A finished result waits
// in an output register while the next request is accepted; a second result
// waits for it to drain. After reset, and after an honored configuration
// write, a clearing pass marks every slot empty first.
// ----------------------------------------------------------------------------
module open_addressed_hash_table_top import ohash_pkg::*; #(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int KEY_BITS  = DEF_KEY_BITS,
  parameter int DATA_BITS = DEF_DATA_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [127:0]      in_tdata,   // key, payload, hash_first, hash_step
  input  logic [1:0]        in_tuser,   // func
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // found_payload, slot_index, zero pad
  output logic [2:0]        out_tuser,  // status
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int IW   = $clog2(SLOTS);
  localparam int PW   = IW + 1;
  localparam int CMPW = (PW > CFG_W) ? PW : CFG_W;
  localparam int W    = 2 + KEY_BITS + DATA_BITS;

  state_t               state_r, state_nxt;
  logic [PW-1:0]        p_r, p_nxt;
  logic [PW-1:0]        cnt_r, cnt_nxt;
  logic [IW-1:0]        clr_r, clr_nxt;
  logic [IW-1:0]        pos_r, pos_nxt;
  logic [IW-1:0]        st_r, st_nxt;
  logic [PW-1:0]        i_r, i_nxt;
  logic                 fs_r, fs_nxt;
  logic [IW-1:0]        fp_r, fp_nxt;
  logic [1:0]           func_r, func_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [DATA_BITS-1:0] data_r, data_nxt;
  logic [HASH_W-1:0]    h2_r, h2_nxt;
  logic [2:0]           res_status_r, res_status_nxt;
  logic [DATA_BITS-1:0] res_pay_r, res_pay_nxt;
  logic [IW-1:0]        res_slot_r, res_slot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_status_r, out_status_nxt;
  logic [DATA_BITS-1:0] out_pay_r, out_pay_nxt;
  logic [IW-1:0]        out_slot_r, out_slot_nxt;

  logic                 cfg_take;
  logic [CMPW-1:0]      cfg_ext;
  logic [CMPW-1:0]      cfg_clamp;
  logic                 mod_start;
  logic [HASH_W-1:0]    mod_arg;
  logic                 mod_done;
  logic [PW-1:0]        mod_rem;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [W-1:0]         wr_data;
  logic                 rd_en;
  logic [W-1:0]         rd_data;
  mark_t                rd_mark;
  logic [KEY_BITS-1:0]  rd_key;
  logic [DATA_BITS-1:0] rd_pay;
  logic                 hit;
  logic                 path_end;
  logic                 fs_now;
  logic [IW-1:0]        fp_now;
  logic [PW-1:0]        sum;
  logic                 in_take;
  logic                 fin_load;

  ohash_mod #(.PW(PW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_arg),
    .divisor  (p_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  ohash_ram #(.SLOTS(SLOTS), .W(W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && (cnt_r == '0);
  assign cfg_ext   = CMPW'(cfg_data);
  assign in_take   = in_tvalid && (state_r == S_IDLE);
  assign fin_load  = !out_valid_r || out_tready;

  assign rd_mark  = mark_t'(rd_data[1:0]);
  assign rd_key   = rd_data[2 +: KEY_BITS];
  assign rd_pay   = rd_data[2 + KEY_BITS +: DATA_BITS];
  assign hit      = (rd_mark == MARK_USED) && (rd_key == key_r);
  assign fs_now   = fs_r || (rd_mark != MARK_USED);
  assign fp_now   = fs_r ? fp_r : pos_r;
  assign path_end = (rd_mark == MARK_EMPTY) || ((i_r + 1'b1) == p_r);
  assign sum      = {1'b0, pos_r} + {1'b0, st_r};

  always_comb begin
    if (cfg_ext == '0) begin
      cfg_clamp = CMPW'(1);
    end else if (cfg_ext > CMPW'(SLOTS)) begin
      cfg_clamp = CMPW'(SLOTS);
    end else begin
      cfg_clamp = cfg_ext;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == IW'(SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_take) begin
          if (in_tuser != FN_INSERT && in_tuser != FN_REMOVE &&
              in_tuser != FN_LOOKUP) begin
            state_nxt = S_FIN;
          end else if (in_tuser == FN_INSERT && cnt_r >= p_r) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (mod_done) state_nxt = S_DIV2;
      end
      S_DIV2: begin
        if (mod_done) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (hit || path_end) state_nxt = S_FIN;
        else                 state_nxt = S_RD;
      end
      S_FIN: begin
        if (fin_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_take) state_nxt = S_CLEAR;
  end

  always_comb begin
    in_tready      = (state_r == S_IDLE);
    p_nxt          = p_r;
    cnt_nxt        = cnt_r;
    clr_nxt        = clr_r;
    pos_nxt        = pos_r;
    st_nxt         = st_r;
    i_nxt          = i_r;
    fs_nxt         = fs_r;
    fp_nxt         = fp_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    data_nxt       = data_r;
    h2_nxt         = h2_r;
    res_status_nxt = res_status_r;
    res_pay_nxt    = res_pay_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pay_nxt    = out_pay_r;
    out_slot_nxt   = out_slot_r;
    mod_start      = 1'b0;
    mod_arg        = in_tdata[95:64];
    wr_en          = 1'b0;
    wr_addr        = clr_r;
    wr_data        = {data_r, key_r, MARK_EMPTY};
    rd_en          = 1'b0;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_take) begin
          func_nxt       = in_tuser;
          key_nxt        = KEY_BITS'(in_tdata[31:0]);
          data_nxt       = DATA_BITS'(in_tdata[63:32]);
          h2_nxt         = in_tdata[127:96];
          res_status_nxt = ST_NOTFOUND;
          res_pay_nxt    = '0;
          res_slot_nxt   = '0;
          if (in_tuser == FN_INSERT && cnt_r >= p_r) begin
            res_status_nxt = ST_FULL;
          end else if (in_tuser == FN_INSERT || in_tuser == FN_REMOVE ||
                       in_tuser == FN_LOOKUP) begin
            mod_start = 1'b1;
          end
        end
      end
      S_DIV1: begin
        if (mod_done) begin
          pos_nxt   = IW'(mod_rem);
          mod_start = 1'b1;
          mod_arg   = h2_r;
        end
      end
      S_DIV2: begin
        if (mod_done) begin
          st_nxt = IW'(mod_rem);
          i_nxt  = '0;
          fs_nxt = 1'b0;
        end
      end
      S_RD: begin
        rd_en = 1'b1;
      end
      S_CHK: begin
        fs_nxt = fs_now;
        fp_nxt = fp_now;
        i_nxt  = i_r + 1'b1;
        pos_nxt = (sum >= p_r) ? IW'(sum - p_r) : IW'(sum);
        if (hit) begin
          res_slot_nxt = pos_r;
          if (func_r == FN_INSERT) begin
            res_status_nxt = ST_DUP;
          end else begin
            res_status_nxt = ST_OK;
            res_pay_nxt    = rd_pay;
            if (func_r == FN_REMOVE) begin
              wr_en   = 1'b1;
              wr_addr = pos_r;
              wr_data = {rd_pay, rd_key, MARK_VACATED};
              if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
            end
          end
        end else if (path_end && func_r == FN_INSERT) begin
          if (fs_now) begin
            wr_en          = 1'b1;
            wr_addr        = fp_now;
            wr_data        = {data_r, key_r, MARK_USED};
            cnt_nxt        = cnt_r + 1'b1;
            res_status_nxt = ST_OK;
            res_slot_nxt   = fp_now;
          end else begin
            res_status_nxt = ST_NOSLOT;
          end
        end
      end
      S_FIN: begin
        if (fin_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pay_nxt    = res_pay_r;
          out_slot_nxt   = res_slot_r;
        end
      end
      default: begin
      end
    endcase
    if (cfg_take) begin
      p_nxt   = PW'(cfg_clamp);
      clr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      p_r         <= PW'(SLOTS);
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    st_r         <= st_nxt;
    i_r          <= i_nxt;
    fs_r         <= fs_nxt;
    fp_r         <= fp_nxt;
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    data_r       <= data_nxt;
    h2_r         <= h2_nxt;
    res_status_r <= res_status_nxt;
    res_pay_r    <= res_pay_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_pay_r    <= out_pay_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b0, 10'(out_slot_r), 32'(out_pay_r)};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= p_r)
    else $error("Entry count exceeds the slot count.");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> ((PW'(pos_r) < p_r) && (PW'(st_r) < p_r)))
    else $error("Probe position or stride outside the slots in use.");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_CLEAR || state_r == S_CHK))
    else $error("Slot memory written outside clearing or probing.");

  a_fin_after_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && !cfg_valid && (hit || path_end)) |=> (state_r == S_FIN))
    else $error("Probe ended without a result.");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the open-addressed hash table. Requests are sent
// on the in_ stream and a local model of the table predicts each result,
// which is compared field by field on the out_ stream. Directed requests
// cover the corner cases; random phases run small and full-size tables
// under varying back-pressure and slot counts.
// ----------------------------------------------------------------------------
module tb import ohash_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = DEF_SLOTS;
  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] payload;
    logic [9:0]  slot;
  } lookup_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [127:0]  in_tdata = '0;
  logic [1:0]    in_tuser = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [47:0]   out_tdata;
  logic [2:0]    out_tuser;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  mark_t        tbl_mark [NSLOT];
  logic [31:0]  tbl_key  [NSLOT];
  logic [31:0]  tbl_data [NSLOT];
  int           entry_cnt;
  int           positions;
  lookup_result_t pending_results[$];
  int           failures = 0;
  int           results_seen = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           quiet_cycles = 0;
  logic [31:0]  key_pool[$];

  open_addressed_hash_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int probe_key(logic [31:0] key, logic [31:0] h1, logic [31:0] h2);
    longint unsigned pos, st;
    pos = longint'(h1) % positions;
    st  = longint'(h2) % positions;
    for (int i = 0; i < positions; i++) begin
      if (tbl_mark[pos] == MARK_EMPTY) return -1;
      if (tbl_mark[pos] == MARK_USED && tbl_key[pos] == key) return int'(pos);
      pos = (pos + st) % positions;
    end
    return -1;
  endfunction

  function automatic int probe_free(logic [31:0] h1, logic [31:0] h2);
    longint unsigned pos, st;
    pos = longint'(h1) % positions;
    st  = longint'(h2) % positions;
    for (int i = 0; i < positions; i++) begin
      if (tbl_mark[pos] != MARK_USED) return int'(pos);
      pos = (pos + st) % positions;
    end
    return -1;
  endfunction

  function automatic lookup_result_t predict_request(logic [1:0] fn, logic [31:0] key,
      logic [31:0] pay, logic [31:0] h1, logic [31:0] h2);
    lookup_result_t r;
    int s;
    r = '{status: ST_NOTFOUND, payload: '0, slot: '0};
    if (fn == FN_INSERT) begin
      if (entry_cnt >= positions) r.status = ST_FULL;
      else begin
        s = probe_key(key, h1, h2);
        if (s >= 0) begin
          r.status = ST_DUP;
          r.slot = s[9:0];
        end else begin
          s = probe_free(h1, h2);
          if (s >= 0) begin
            tbl_mark[s] = MARK_USED;
            tbl_key[s] = key;
            tbl_data[s] = pay;
            entry_cnt++;
            r.status = ST_OK;
            r.slot = s[9:0];
          end else r.status = ST_NOSLOT;
        end
      end
    end else if (fn == FN_REMOVE || fn == FN_LOOKUP) begin
      s = probe_key(key, h1, h2);
      if (s >= 0) begin
        r.status = ST_OK;
        r.payload = tbl_data[s];
        r.slot = s[9:0];
        if (fn == FN_REMOVE) begin
          tbl_mark[s] = MARK_VACATED;
          if (entry_cnt > 0) entry_cnt--;
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(logic [1:0] fn, logic [31:0] key, logic [31:0] pay,
      logic [31:0] h1, logic [31:0] h2);
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {h2, h1, pay, key};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_request(fn, key, pay, h1, h2));
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_positions(logic [CFG_W-1:0] value);
    int v;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (entry_cnt == 0) begin
      v = int'(value);
      if (v == 0) v = 1;
      if (v > NSLOT) v = NSLOT;
      positions = v;
      foreach (tbl_mark[i]) tbl_mark[i] = MARK_EMPTY;
    end
  endtask

  task automatic empty_table();
    int p;
    p = positions;
    for (int s = 0; s < p; s++)
      if (tbl_mark[s] == MARK_USED) send_request(FN_REMOVE, tbl_key[s], $urandom, s, 0);
    wait_drained();
  endtask

  function automatic logic [31:0] hash_a(logic [31:0] key);
    return key * 32'h9E3779B1 ^ 32'h5BD1E995;
  endfunction

  function automatic logic [31:0] hash_b(logic [31:0] key);
    return {key[15:0], key[31:16]} * 32'h85EBCA6B + 32'hC2B2AE35;
  endfunction

  task automatic send_random_item();
    logic [31:0] key, h1, h2;
    logic [1:0] fn;
    int pick;
    key = key_pool[$urandom_range(key_pool.size() - 1)];
    pick = $urandom_range(99);
    if (pick < 45) fn = FN_INSERT;
    else if (pick < 70) fn = FN_REMOVE;
    else if (pick < 95) fn = FN_LOOKUP;
    else fn = FN_UNUSED;
    if ($urandom_range(99) < 85) begin
      h1 = hash_a(key);
      h2 = hash_b(key);
    end else begin
      h1 = $urandom;
      h2 = $urandom;
    end
    send_request(fn, key, $urandom, h1, h2);
  endtask

  task automatic test_directed();
    send_request(FN_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0);
    send_request(FN_REMOVE, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(FN_UNUSED, 32'h1234, 32'hFFFFFFFF, 32'h5, 32'h7);
    send_request(FN_INSERT, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(FN_INSERT, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(FN_INSERT, 32'h0, 32'hA5A5A5A5, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(FN_LOOKUP, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(FN_REMOVE, 32'h0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(FN_LOOKUP, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(FN_INSERT, 32'h55AA55AA, 32'h12345678, 32'hFFFFFFFF, 32'h0);
    send_request(FN_LOOKUP, 32'h55AA55AA, 32'h0, 32'h0, 32'h0);
    // The table holds entries here, so this write must be ignored.
    write_positions(11'd4);
    send_request(FN_LOOKUP, 32'h55AA55AA, 32'h0, 32'hFFFFFFFF, 32'h0);
    empty_table();
    write_positions(11'd0);
    send_request(FN_INSERT, 32'h11, 32'h22, 32'h3, 32'h9);
    send_request(FN_INSERT, 32'h12, 32'h23, 32'h3, 32'h9);
    send_request(FN_INSERT, 32'h11, 32'h23, 32'h3, 32'h9);
    send_request(FN_REMOVE, 32'h11, 32'h0, 32'h0, 32'h0);
    write_positions(11'd2);
    send_request(FN_INSERT, 32'h31, 32'h41, 32'h0, 32'h0);
    send_request(FN_INSERT, 32'h32, 32'h42, 32'h0, 32'h0);
    send_request(FN_LOOKUP, 32'h32, 32'h0, 32'h0, 32'h0);
    empty_table();
    write_positions(11'h7FF);
  endtask

  task automatic test_random_phase(int s_idle, int r_idle);
    int sizes[8] = '{1, 2, 3, 7, 16, 31, 64, 1024};
    int p;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int k = 0; k < 6; k++) begin
      p = (k == 5) ? $urandom_range(1025, 2047) :
          (k == 4) ? $urandom_range(1, 40) : sizes[$urandom_range(7)];
      empty_table();
      write_positions(p[CFG_W-1:0]);
      key_pool.delete();
      for (int i = 0; i < ((positions < 24) ? 2 * positions + 2 : 48); i++)
        key_pool.push_back($urandom);
      for (int i = 0; i < 40; i++) begin
        if (k == 2 && i == 20) wait_drained();
        send_random_item();
      end
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          failures++;
        end
        if (out_tdata[31:0] !== want.payload) begin
          $error("found_payload: expected %h, got %h", want.payload, out_tdata[31:0]);
          failures++;
        end
        if (out_tdata[41:32] !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, out_tdata[41:32]);
          failures++;
        end
      end
    end
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("open_addressed_hash_table_top: mismatch");
      $finish;
    end
  end

  initial begin
    foreach (tbl_mark[i]) tbl_mark[i] = MARK_EMPTY;
    entry_cnt = 0;
    positions = NSLOT;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_phase(16, 51);
    test_random_phase(51, 16);
    test_random_phase(0, 0);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered directed corner cases and random traffic on table sizes 1 to %0d,",
             NSLOT);
    $display("with %0d results checked under three back-pressure mixes.", results_seen);
    if (failures == 0 && pending_results.size() == 0)
      $display("open_addressed_hash_table_top: match");
    else
      $display("open_addressed_hash_table_top: mismatch");
    $finish;
  end

endmodule
